// ===== design/i2cmra_pkg.sv =====
// shared types and codes of the i2c master register access unit
package i2cmra_pkg;

   localparam logic [1:0] ACT_BEGIN_WRITE = 2'd0;
   localparam logic [1:0] ACT_BEGIN_READ  = 2'd1;
   localparam logic [1:0] ACT_WRITE_DATA  = 2'd2;
   localparam logic [1:0] ACT_READ_DATA   = 2'd3;

   localparam logic [1:0] KIND_START    = 2'd0;
   localparam logic [1:0] KIND_STOP     = 2'd1;
   localparam logic [1:0] KIND_DRIVEN   = 2'd2;
   localparam logic [1:0] KIND_RELEASED = 2'd3;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_NACK   = 2'd1;
   localparam logic [1:0] STATUS_REJECT = 2'd2;

   localparam logic RW_WRITE = 1'b0;
   localparam logic RW_READ  = 1'b1;

   localparam logic [2:0] BIT_LAST = 3'd7;

   typedef struct packed {
      logic [1:0] action;
      logic [6:0] slave_addr;
      logic [7:0] sub_addr;
      logic [7:0] write_data;
      logic       last_byte;
      logic [7:0] slave_bits;
   } req_type;

   typedef struct packed {
      logic [1:0] slot_kind;
      logic       sda_level;
      logic [7:0] read_value;
      logic [1:0] status;
      logic       last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START1,
      ST_DEV_W,
      ST_ACK_DEV,
      ST_REG,
      ST_ACK_REG,
      ST_START2,
      ST_DEV_R,
      ST_ACK_DEV_R,
      ST_WDATA,
      ST_ACK_DATA,
      ST_RDATA,
      ST_MACK,
      ST_STOP,
      ST_REJECT
   } state_type;

   typedef struct packed {
      logic       tx_load;
      logic [7:0] tx_data;
      logic       tx_shift;
      logic       rx_load;
      logic [7:0] rx_data;
      logic       rx_shift_left;
      logic       rx_shift_right;
   } shift_ctrl_type;

   typedef struct packed {
      logic       tx_bit;
      logic       rx_msb;
      logic       rx_lsb;
      logic [7:0] rval;
   } shift_stat_type;

endpackage

// ===== design/i2cmra_chan_if.sv =====
// valid/ready channel carrying one payload per transfer
interface i2cmra_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/i2cmra_shifter.sv =====
// bit-serial transmit and sample shift registers with read byte assembly
module i2cmra_shifter (
   input  logic                     clock,
   input  i2cmra_pkg::shift_ctrl_type ctrl,
   output i2cmra_pkg::shift_stat_type stat
);

   logic [7:0] tx_ff, tx_in;
   logic [7:0] rx_ff, rx_in;
   logic [7:0] rval_ff, rval_in;

   always_comb begin
      tx_in = tx_ff;
      if (ctrl.tx_load) begin
         tx_in = ctrl.tx_data;
      end else if (ctrl.tx_shift) begin
         tx_in = {tx_ff[6:0], 1'b0};
      end
   end

   always_comb begin
      rx_in   = rx_ff;
      rval_in = rval_ff;
      if (ctrl.rx_load) begin
         rx_in   = ctrl.rx_data;
         rval_in = '0;
      end else if (ctrl.rx_shift_left) begin
         rx_in   = {rx_ff[6:0], 1'b0};
         rval_in = {rval_ff[6:0], rx_ff[7]};
      end else if (ctrl.rx_shift_right) begin
         rx_in = {1'b0, rx_ff[7:1]};
      end
   end

   always_ff @(posedge clock) begin
      tx_ff   <= tx_in;
      rx_ff   <= rx_in;
      rval_ff <= rval_in;
   end

   assign stat.tx_bit = tx_ff[7];
   assign stat.rx_msb = rx_ff[7];
   assign stat.rx_lsb = rx_ff[0];
   assign stat.rval   = rval_ff;

endmodule

// ===== design/i2cmra_seq.sv =====
// bus slot sequencer: command decode, transaction state and slot generation
module i2cmra_seq (
   input  logic                       clock,
   input  logic                       reset,
   i2cmra_chan_if.sink                req_chan,
   input  logic                       slot_free,
   input  i2cmra_pkg::shift_stat_type stat,
   output i2cmra_pkg::shift_ctrl_type ctrl,
   output logic                       emit,
   output i2cmra_pkg::rsp_type        slot
);

   i2cmra_pkg::state_type state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       bus_open_ff, bus_open_in;
   logic [1:0] act_ff, act_in;
   logic [6:0] dev_ff, dev_in;
   logic [7:0] reg_ff, reg_in;
   logic       last_ff, last_in;
   logic [1:0] status_ff, status_in;
   logic       accept;
   logic       is_begin;

   assign req_chan.ready = (state_ff == i2cmra_pkg::ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign is_begin       = (req_chan.payload.action == i2cmra_pkg::ACT_BEGIN_WRITE) ||
                           (req_chan.payload.action == i2cmra_pkg::ACT_BEGIN_READ);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         i2cmra_pkg::ST_IDLE: begin
            if (accept) begin
               if (is_begin) begin
                  state_in = i2cmra_pkg::ST_START1;
               end else if (!bus_open_ff) begin
                  state_in = i2cmra_pkg::ST_REJECT;
               end else if (req_chan.payload.action == i2cmra_pkg::ACT_WRITE_DATA) begin
                  state_in = i2cmra_pkg::ST_WDATA;
               end else begin
                  state_in = i2cmra_pkg::ST_RDATA;
               end
            end
         end
         i2cmra_pkg::ST_START1: begin
            if (slot_free) state_in = i2cmra_pkg::ST_DEV_W;
         end
         i2cmra_pkg::ST_DEV_W: begin
            if (slot_free && cnt_ff == i2cmra_pkg::BIT_LAST) state_in = i2cmra_pkg::ST_ACK_DEV;
         end
         i2cmra_pkg::ST_ACK_DEV: begin
            if (slot_free) begin
               state_in = stat.rx_lsb ? i2cmra_pkg::ST_STOP : i2cmra_pkg::ST_REG;
            end
         end
         i2cmra_pkg::ST_REG: begin
            if (slot_free && cnt_ff == i2cmra_pkg::BIT_LAST) state_in = i2cmra_pkg::ST_ACK_REG;
         end
         i2cmra_pkg::ST_ACK_REG: begin
            if (slot_free) begin
               state_in = (act_ff == i2cmra_pkg::ACT_BEGIN_READ) ? i2cmra_pkg::ST_START2
                                                                 : i2cmra_pkg::ST_IDLE;
            end
         end
         i2cmra_pkg::ST_START2: begin
            if (slot_free) state_in = i2cmra_pkg::ST_DEV_R;
         end
         i2cmra_pkg::ST_DEV_R: begin
            if (slot_free && cnt_ff == i2cmra_pkg::BIT_LAST) state_in = i2cmra_pkg::ST_ACK_DEV_R;
         end
         i2cmra_pkg::ST_ACK_DEV_R: begin
            if (slot_free) state_in = i2cmra_pkg::ST_IDLE;
         end
         i2cmra_pkg::ST_WDATA: begin
            if (slot_free && cnt_ff == i2cmra_pkg::BIT_LAST) state_in = i2cmra_pkg::ST_ACK_DATA;
         end
         i2cmra_pkg::ST_ACK_DATA: begin
            if (slot_free) state_in = last_ff ? i2cmra_pkg::ST_STOP : i2cmra_pkg::ST_IDLE;
         end
         i2cmra_pkg::ST_RDATA: begin
            if (slot_free && cnt_ff == i2cmra_pkg::BIT_LAST) state_in = i2cmra_pkg::ST_MACK;
         end
         i2cmra_pkg::ST_MACK: begin
            if (slot_free) state_in = last_ff ? i2cmra_pkg::ST_STOP : i2cmra_pkg::ST_IDLE;
         end
         i2cmra_pkg::ST_STOP,
         i2cmra_pkg::ST_REJECT: begin
            if (slot_free) state_in = i2cmra_pkg::ST_IDLE;
         end
         default: state_in = i2cmra_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      ctrl             = '0;
      slot             = '0;
      slot.status      = status_ff;
      emit             = 1'b0;
      cnt_in           = cnt_ff;
      bus_open_in      = bus_open_ff;
      act_in           = act_ff;
      dev_in           = dev_ff;
      reg_in           = reg_ff;
      last_in          = last_ff;
      status_in        = status_ff;
      if (state_ff == i2cmra_pkg::ST_IDLE) begin
         if (accept) begin
            act_in        = req_chan.payload.action;
            dev_in        = req_chan.payload.slave_addr;
            reg_in        = req_chan.payload.sub_addr;
            last_in       = req_chan.payload.last_byte;
            cnt_in        = '0;
            ctrl.tx_load  = 1'b1;
            ctrl.tx_data  = req_chan.payload.write_data;
            ctrl.rx_load  = 1'b1;
            ctrl.rx_data  = req_chan.payload.slave_bits;
            if (is_begin) begin
               status_in = req_chan.payload.slave_bits[0] ? i2cmra_pkg::STATUS_NACK
                                                          : i2cmra_pkg::STATUS_OK;
            end else if (!bus_open_ff) begin
               status_in = i2cmra_pkg::STATUS_REJECT;
            end else begin
               status_in = i2cmra_pkg::STATUS_OK;
            end
         end
      end else if (slot_free) begin
         emit = 1'b1;
         unique case (state_ff)
            i2cmra_pkg::ST_START1,
            i2cmra_pkg::ST_START2: begin
               slot.slot_kind = i2cmra_pkg::KIND_START;
               slot.sda_level = 1'b0;
               ctrl.tx_load   = 1'b1;
               ctrl.tx_data   = {dev_ff, (state_ff == i2cmra_pkg::ST_START2) ?
                                         i2cmra_pkg::RW_READ : i2cmra_pkg::RW_WRITE};
            end
            i2cmra_pkg::ST_DEV_W,
            i2cmra_pkg::ST_REG,
            i2cmra_pkg::ST_DEV_R,
            i2cmra_pkg::ST_WDATA: begin
               slot.slot_kind = i2cmra_pkg::KIND_DRIVEN;
               slot.sda_level = stat.tx_bit;
               ctrl.tx_shift  = 1'b1;
               cnt_in         = cnt_ff + 3'd1;
            end
            i2cmra_pkg::ST_ACK_DEV: begin
               slot.slot_kind      = i2cmra_pkg::KIND_RELEASED;
               slot.sda_level      = stat.rx_lsb;
               ctrl.rx_shift_right = 1'b1;
               ctrl.tx_load        = 1'b1;
               ctrl.tx_data        = reg_ff;
            end
            i2cmra_pkg::ST_ACK_REG: begin
               slot.slot_kind      = i2cmra_pkg::KIND_RELEASED;
               slot.sda_level      = stat.rx_lsb;
               ctrl.rx_shift_right = 1'b1;
               if (act_ff != i2cmra_pkg::ACT_BEGIN_READ) begin
                  slot.last   = 1'b1;
                  bus_open_in = 1'b1;
               end
            end
            i2cmra_pkg::ST_ACK_DEV_R: begin
               slot.slot_kind = i2cmra_pkg::KIND_RELEASED;
               slot.sda_level = stat.rx_lsb;
               slot.last      = 1'b1;
               bus_open_in    = 1'b1;
            end
            i2cmra_pkg::ST_ACK_DATA: begin
               slot.slot_kind = i2cmra_pkg::KIND_RELEASED;
               slot.sda_level = stat.rx_lsb;
               slot.last      = !last_ff;
            end
            i2cmra_pkg::ST_RDATA: begin
               slot.slot_kind     = i2cmra_pkg::KIND_RELEASED;
               slot.sda_level     = stat.rx_msb;
               ctrl.rx_shift_left = 1'b1;
               cnt_in             = cnt_ff + 3'd1;
            end
            i2cmra_pkg::ST_MACK: begin
               slot.slot_kind = i2cmra_pkg::KIND_DRIVEN;
               slot.sda_level = last_ff;
               if (!last_ff) begin
                  slot.last       = 1'b1;
                  slot.read_value = stat.rval;
               end
            end
            i2cmra_pkg::ST_STOP: begin
               slot.slot_kind = i2cmra_pkg::KIND_STOP;
               slot.sda_level = 1'b1;
               slot.last      = 1'b1;
               bus_open_in    = 1'b0;
               if (act_ff == i2cmra_pkg::ACT_READ_DATA) slot.read_value = stat.rval;
            end
            i2cmra_pkg::ST_REJECT: begin
               slot.slot_kind = i2cmra_pkg::KIND_STOP;
               slot.sda_level = 1'b1;
               slot.last      = 1'b1;
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= i2cmra_pkg::ST_IDLE;
         cnt_ff      <= '0;
         bus_open_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         bus_open_ff <= bus_open_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      dev_ff    <= dev_in;
      reg_ff    <= reg_in;
      last_ff   <= last_in;
      status_ff <= status_in;
   end

`ifndef ASSERT_OFF
   a_stop_closes_bus: assert property (@(posedge clock) disable iff (reset)
      (emit && slot.slot_kind == i2cmra_pkg::KIND_STOP) |=> !bus_open_ff)
      else $error("bus still open after a stop slot");

   a_reject_single_stop: assert property (@(posedge clock) disable iff (reset)
      (emit && slot.status == i2cmra_pkg::STATUS_REJECT) |->
      (slot.last && slot.slot_kind == i2cmra_pkg::KIND_STOP))
      else $error("rejected command produced bus activity");

   a_count_in_byte: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != 3'd0) |->
      (state_ff == i2cmra_pkg::ST_DEV_W || state_ff == i2cmra_pkg::ST_REG ||
       state_ff == i2cmra_pkg::ST_DEV_R || state_ff == i2cmra_pkg::ST_WDATA ||
       state_ff == i2cmra_pkg::ST_RDATA))
      else $error("bit count left nonzero outside a byte");

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (emit && slot.last) |=> (state_ff == i2cmra_pkg::ST_IDLE))
      else $error("sequencer kept running after final slot");
`endif

endmodule

// ===== design/i2c_master_register_access_unit.sv =====
// top level of the i2c master register access unit
// a command transfer is registered in the sequencer state, then its first slot in the output register
// throughput: one bus slot per cycle while the output register is empty or rsp_chan is ready;
//   a command issues 1 slot if rejected and up to 29 slots for begin read, set by the slot sequencer
// only one command is in flight; the next transfer is taken once the last slot is issued
// synchronous reset closes any open transaction and empties the output register
module i2c_master_register_access_unit (
   input  logic          clock,
   input  logic          reset,
   i2cmra_chan_if.sink   req_chan,
   i2cmra_chan_if.source rsp_chan
);

   i2cmra_pkg::shift_ctrl_type ctrl;
   i2cmra_pkg::shift_stat_type stat;
   i2cmra_pkg::rsp_type        slot;
   i2cmra_pkg::rsp_type        rsp_ff, rsp_in;
   logic                       emit;
   logic                       slot_free;
   logic                       rsp_valid_ff, rsp_valid_in;

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   i2cmra_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .slot_free (slot_free),
      .stat      (stat),
      .ctrl      (ctrl),
      .emit      (emit),
      .slot      (slot)
   );

   i2cmra_shifter u_shifter (
      .clock (clock),
      .ctrl  (ctrl),
      .stat  (stat)
   );

   // output register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_in       = slot;
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

endmodule
